/* rtl/metm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// metm_pkg: shared types and constants of the mesh edge twin matcher
// Field widths, status codes, state encodings and the table entry layout.
// ----------------------------------------------------------------------------
package metm_pkg;

    localparam int unsigned VERTEX_W      = 32;
    localparam int unsigned KEY_W         = 2 * VERTEX_W;
    localparam int unsigned TRI_W         = 30;
    localparam int unsigned EDGE_W        = 2;
    localparam int unsigned EDGES_PER_TRI = 3;

    localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(EDGES_PER_TRI - 1);

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam int unsigned PROBE_LIMIT_DEF   = 8;

    // Golden-ratio multiplier of the key hash, split into 32-bit halves.
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LK_HASH,
        S_LK_READ,
        S_LK_CHECK,
        S_IN_HASH,
        S_IN_READ,
        S_IN_CHECK,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_P0,
        HS_P1,
        HS_P2,
        HS_QUO,
        HS_REM,
        HS_FIX
    } t_hash_step;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TRI_W-1:0]  tri_id;
        logic [EDGE_W-1:0] edge_idx;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/metm_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// metm_req_if: triangle request channel
// Valid/ready channel carrying one triangle and its new-mesh flag.
// ----------------------------------------------------------------------------
interface metm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          new_mesh;
    logic [metm_pkg::VERTEX_W-1:0] vertex_a;
    logic [metm_pkg::VERTEX_W-1:0] vertex_b;
    logic [metm_pkg::VERTEX_W-1:0] vertex_c;

    modport source (output valid, new_mesh, vertex_a, vertex_b, vertex_c, input ready);
    modport sink   (input valid, new_mesh, vertex_a, vertex_b, vertex_c, output ready);
endinterface
`default_nettype wire

/* rtl/metm_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// metm_res_if: edge result channel
// Valid/ready channel carrying one edge match result.
// ----------------------------------------------------------------------------
interface metm_res_if;
    logic                        valid;
    logic                        ready;
    logic [metm_pkg::TRI_W-1:0]  triangle_num;
    logic [metm_pkg::EDGE_W-1:0] edge_index;
    logic                        found;
    logic [metm_pkg::TRI_W-1:0]  neighbor_triangle;
    logic [metm_pkg::EDGE_W-1:0] neighbor_edge;
    logic [1:0]                  status;
    logic                        last_of_triangle;

    modport source (output valid, triangle_num, edge_index, found, neighbor_triangle,
                    neighbor_edge, status, last_of_triangle, input ready);
    modport sink   (input valid, triangle_num, edge_index, found, neighbor_triangle,
                    neighbor_edge, status, last_of_triangle, output ready);
endinterface
`default_nettype wire

/* rtl/metm_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// metm_hash: multi-cycle edge key hash
// Multiplicative hash of a 64-bit key reduced to a table slot, using one
// shared 32x32 multiplier over six steps.
// ----------------------------------------------------------------------------
module metm_hash #(
    parameter  int unsigned TABLE_ENTRIES = metm_pkg::TABLE_ENTRIES_DEF,
    localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [metm_pkg::KEY_W-1:0] i_key,
    output logic                            o_done,
    output logic [SLOT_W-1:0]               o_slot
);

    localparam logic [31:0] N_CONST = 32'(TABLE_ENTRIES);
    // Reciprocal rounded down; the quotient estimate is then short by at most one.
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_ENTRIES);

    metm_pkg::t_hash_step r_step;
    metm_pkg::t_hash_step n_step;

    logic [metm_pkg::KEY_W-1:0] r_key;
    logic [31:0]                r_acc;
    logic [31:0]                r_q;
    logic [SLOT_W-1:0]          r_slot;
    logic                       r_done;
    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [63:0]                mul_p;
    logic [31:0]                rem_fix;

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            metm_pkg::HS_IDLE: if (i_start) n_step = metm_pkg::HS_P0;
            metm_pkg::HS_P0:   n_step = metm_pkg::HS_P1;
            metm_pkg::HS_P1:   n_step = metm_pkg::HS_P2;
            metm_pkg::HS_P2:   n_step = metm_pkg::HS_QUO;
            metm_pkg::HS_QUO:  n_step = metm_pkg::HS_REM;
            metm_pkg::HS_REM:  n_step = metm_pkg::HS_FIX;
            metm_pkg::HS_FIX:  n_step = metm_pkg::HS_IDLE;
            default:           n_step = metm_pkg::HS_IDLE;
        endcase
    end

    // Only the upper product word of the 64-bit hash is needed:
    // hi(v*Ml) + lo(u*Ml) + lo(v*Mh), all modulo 2^32.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            metm_pkg::HS_P0: begin
                mul_a = r_key[31:0];
                mul_b = metm_pkg::HASH_MUL_LO;
            end
            metm_pkg::HS_P1: begin
                mul_a = r_key[63:32];
                mul_b = metm_pkg::HASH_MUL_LO;
            end
            metm_pkg::HS_P2: begin
                mul_a = r_key[31:0];
                mul_b = metm_pkg::HASH_MUL_HI;
            end
            metm_pkg::HS_QUO: begin
                mul_a = r_acc;
                mul_b = RECIP;
            end
            metm_pkg::HS_REM: begin
                mul_a = r_q;
                mul_b = N_CONST;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign rem_fix = (r_acc >= N_CONST) ? (r_acc - N_CONST) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= metm_pkg::HS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == metm_pkg::HS_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            metm_pkg::HS_IDLE: if (i_start) r_key <= i_key;
            metm_pkg::HS_P0:   r_acc  <= mul_p[63:32];
            metm_pkg::HS_P1:   r_acc  <= r_acc + mul_p[31:0];
            metm_pkg::HS_P2:   r_acc  <= r_acc + mul_p[31:0];
            metm_pkg::HS_QUO:  r_q    <= mul_p[63:32];
            metm_pkg::HS_REM:  r_acc  <= r_acc - mul_p[31:0];
            metm_pkg::HS_FIX:  r_slot <= rem_fix[SLOT_W-1:0];
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule
`default_nettype wire

/* rtl/mesh_edge_twin_matcher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_edge_twin_matcher: half-edge twin matching over a hashed edge table
// Numbers incoming triangles, looks up the reversed version of each directed
// edge and either reports the twin or records the edge for later triangles.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Contents
//  --------+-----------+---------------------------------------------------
//  i_req   | in        | new_mesh flag and three 32-bit vertex indices
//  o_res   | out       | one result per edge, three per triangle
//
//  A request is taken in the idle state. Each edge is then hashed and the
//  reversed key looked up over up to PROBE_LIMIT probed slots; on a miss
//  the edge's own key is hashed and probed for the insert, which writes the
//  first free slot or the slot of the same key, or reports FULL when the
//  probe run finds neither; then the output register is loaded. A triangle
//  turned away by the full counter skips the table and emits its three
//  OVERFLOW results. The hash multiplier is shared; the table has one port.
//  After reset, and after every request with new_mesh set, the table is swept
//  over every slot with i_req.ready low. A stalled o_res only holds the block
//  once a second result is ready while the first still waits.
//
module mesh_edge_twin_matcher #(
    parameter int unsigned TABLE_ENTRIES = metm_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned PROBE_LIMIT   = metm_pkg::PROBE_LIMIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    metm_req_if.sink    i_req,
    metm_res_if.source  o_res
);

    localparam int unsigned SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int unsigned PROBE_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int unsigned TRI_W   = metm_pkg::TRI_W;
    localparam int unsigned EDGE_W  = metm_pkg::EDGE_W;
    localparam int unsigned VTX_W   = metm_pkg::VERTEX_W;
    localparam int unsigned KEY_W   = metm_pkg::KEY_W;

    // The edge table. Each word carries its own valid bit, which the sweep
    // clears; key, triangle and edge are only looked at where valid is set.
    metm_pkg::t_entry mem [TABLE_ENTRIES];
    metm_pkg::t_entry r_rdata;

    metm_pkg::t_state r_state;
    metm_pkg::t_state n_state;

    logic [SLOT_W-1:0]  r_clr_addr;
    logic               r_item;
    logic               r_full;
    logic [TRI_W-1:0]   r_tri;
    logic [EDGE_W-1:0]  r_edge;
    logic [PROBE_W-1:0] r_probe;
    logic               r_hash_start;
    logic               n_hash_start;
    logic [SLOT_W-1:0]  r_slot;
    logic [VTX_W-1:0]   r_vtx_a;
    logic [VTX_W-1:0]   r_vtx_b;
    logic [VTX_W-1:0]   r_vtx_c;

    // Result of the edge in progress.
    logic               r_found;
    logic [TRI_W-1:0]   r_nb_tri;
    logic [EDGE_W-1:0]  r_nb_edge;
    metm_pkg::t_status  r_status;

    // Output register.
    logic               r_out_valid;
    logic [TRI_W-1:0]   r_o_tri;
    logic [EDGE_W-1:0]  r_o_edge;
    logic               r_o_found;
    logic [TRI_W-1:0]   r_o_nb_tri;
    logic [EDGE_W-1:0]  r_o_nb_edge;
    logic [1:0]         r_o_status;
    logic               r_o_last;

    logic               req_ready;
    logic               req_accept;
    logic               emit_load;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_addr;
    metm_pkg::t_entry   mem_wdata;
    logic               clear_last;
    logic               probe_last;
    logic [SLOT_W-1:0]  slot_next;
    logic [VTX_W-1:0]   edge_u;
    logic [VTX_W-1:0]   edge_v;
    logic [KEY_W-1:0]   key_lk;
    logic [KEY_W-1:0]   key_in;
    logic [KEY_W-1:0]   hash_key;
    logic               hash_done;
    logic [SLOT_W-1:0]  hash_slot;
    logic               lk_hit;
    logic               lk_miss;
    logic               in_take;
    logic               in_drop;
    logic               advance;

    // ------------------------------------------------------------------
    // Edge endpoints: (a,b), (b,c), (c,a). The twin search uses the
    // reversed key (v,u), the insert uses the edge's own key (u,v).
    // ------------------------------------------------------------------
    always_comb begin
        case (r_edge)
            2'd0: begin
                edge_u = r_vtx_a;
                edge_v = r_vtx_b;
            end
            2'd1: begin
                edge_u = r_vtx_b;
                edge_v = r_vtx_c;
            end
            default: begin
                edge_u = r_vtx_c;
                edge_v = r_vtx_a;
            end
        endcase
    end

    assign key_lk   = {edge_v, edge_u};
    assign key_in   = {edge_u, edge_v};
    assign hash_key = (r_state == metm_pkg::S_LK_HASH) ? key_lk : key_in;

    metm_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hash_start),
        .i_key   (hash_key),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    // ------------------------------------------------------------------
    // Probe decisions on the entry read in the previous cycle.
    // ------------------------------------------------------------------
    assign probe_last = (r_probe == PROBE_W'(PROBE_LIMIT - 1));
    assign slot_next  = (r_slot == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : (r_slot + 1'b1);
    assign clear_last = (r_clr_addr == SLOT_W'(TABLE_ENTRIES - 1));

    // Entries are never removed, so an empty slot ends the twin search.
    assign lk_hit  = r_rdata.valid && (r_rdata.key == key_lk);
    assign lk_miss = !r_rdata.valid || (!lk_hit && probe_last);
    // An insert takes the first empty slot or the slot that holds its own key.
    assign in_take = !r_rdata.valid || (r_rdata.key == key_in);
    assign in_drop = !in_take && probe_last;

    assign advance = ((r_state == metm_pkg::S_LK_CHECK) && !lk_hit && !lk_miss) ||
                     ((r_state == metm_pkg::S_IN_CHECK) && !in_take && !in_drop);

    assign req_accept = i_req.valid && req_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            metm_pkg::S_CLEAR: begin
                if (clear_last) n_state = r_item ? metm_pkg::S_LK_HASH : metm_pkg::S_IDLE;
            end
            metm_pkg::S_IDLE: begin
                if (req_accept) begin
                    if (i_req.new_mesh)  n_state = metm_pkg::S_CLEAR;
                    else if (r_full)     n_state = metm_pkg::S_EMIT;
                    else                 n_state = metm_pkg::S_LK_HASH;
                end
            end
            metm_pkg::S_LK_HASH: if (hash_done) n_state = metm_pkg::S_LK_READ;
            metm_pkg::S_LK_READ: n_state = metm_pkg::S_LK_CHECK;
            metm_pkg::S_LK_CHECK: begin
                if (lk_hit)       n_state = metm_pkg::S_EMIT;
                else if (lk_miss) n_state = metm_pkg::S_IN_HASH;
                else              n_state = metm_pkg::S_LK_READ;
            end
            metm_pkg::S_IN_HASH: if (hash_done) n_state = metm_pkg::S_IN_READ;
            metm_pkg::S_IN_READ: n_state = metm_pkg::S_IN_CHECK;
            metm_pkg::S_IN_CHECK: begin
                if (in_take)      n_state = metm_pkg::S_WRITE;
                else if (in_drop) n_state = metm_pkg::S_EMIT;
                else              n_state = metm_pkg::S_IN_READ;
            end
            metm_pkg::S_WRITE: n_state = metm_pkg::S_EMIT;
            metm_pkg::S_EMIT: begin
                if (emit_load) begin
                    if (r_edge == metm_pkg::EDGE_LAST) n_state = metm_pkg::S_IDLE;
                    else if (r_full)                   n_state = metm_pkg::S_EMIT;
                    else                               n_state = metm_pkg::S_LK_HASH;
                end
            end
            default: n_state = metm_pkg::S_IDLE;
        endcase
    end

    // The hash start is registered so that the key registers are settled
    // in the cycle the hash unit captures them.
    assign n_hash_start = (n_state != r_state) &&
                          ((n_state == metm_pkg::S_LK_HASH) || (n_state == metm_pkg::S_IN_HASH));

    // ------------------------------------------------------------------
    // Sequencer: outputs. The table has one port; the sweep and the insert
    // write, the probe states read. A write always lies at least one hash
    // run ahead of the next read, so no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb begin
        req_ready = 1'b0;
        emit_load = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_slot;
        mem_wdata = '0;
        unique case (r_state)
            metm_pkg::S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            metm_pkg::S_IDLE: req_ready = 1'b1;
            metm_pkg::S_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = '{valid: 1'b1, key: key_in, tri_id: r_tri, edge_idx: r_edge};
            end
            metm_pkg::S_EMIT: emit_load = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= metm_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_item       <= 1'b0;
            r_full       <= 1'b0;
            r_tri        <= '0;
            r_edge       <= '0;
            r_probe      <= '0;
            r_hash_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hash_start <= n_hash_start;

            if (r_state == metm_pkg::S_CLEAR) begin
                r_clr_addr <= clear_last ? '0 : (r_clr_addr + 1'b1);
            end

            if (req_accept) begin
                r_item <= 1'b1;
                r_edge <= '0;
                if (i_req.new_mesh) begin
                    r_tri  <= '0;
                    r_full <= 1'b0;
                end
            end

            if (hash_done) begin
                r_probe <= '0;
            end else if (advance) begin
                r_probe <= r_probe + 1'b1;
            end

            // Triangle numbering advances after its third result; a rejected
            // triangle (counter already full) leaves it alone.
            if (emit_load) begin
                if (r_edge == metm_pkg::EDGE_LAST) begin
                    r_item <= 1'b0;
                    if (!r_full) begin
                        if (r_tri == {TRI_W{1'b1}}) begin
                            r_tri  <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_tri <= r_tri + 1'b1;
                        end
                    end
                end else begin
                    r_edge <= r_edge + 1'b1;
                end
            end

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_vtx_a   <= i_req.vertex_a;
            r_vtx_b   <= i_req.vertex_b;
            r_vtx_c   <= i_req.vertex_c;
            // Preset for a rejected triangle; every normal edge overwrites it.
            r_found   <= 1'b0;
            r_nb_tri  <= '0;
            r_nb_edge <= '0;
            r_status  <= metm_pkg::ST_OVERFLOW;
        end

        if (hash_done) begin
            r_slot <= hash_slot;
        end else if (advance) begin
            r_slot <= slot_next;
        end

        if ((r_state == metm_pkg::S_LK_CHECK) && lk_hit) begin
            r_found   <= 1'b1;
            r_nb_tri  <= r_rdata.tri_id;
            r_nb_edge <= r_rdata.edge_idx;
            r_status  <= metm_pkg::ST_OK;
        end

        if ((r_state == metm_pkg::S_IN_CHECK) && (in_take || in_drop)) begin
            r_found   <= 1'b0;
            r_nb_tri  <= '0;
            r_nb_edge <= '0;
            r_status  <= in_take ? metm_pkg::ST_OK : metm_pkg::ST_FULL;
        end

        if (emit_load) begin
            r_o_tri     <= r_tri;
            r_o_edge    <= r_edge;
            r_o_found   <= r_found;
            r_o_nb_tri  <= r_nb_tri;
            r_o_nb_edge <= r_nb_edge;
            r_o_status  <= r_status;
            r_o_last    <= (r_edge == metm_pkg::EDGE_LAST);
        end
    end

    assign i_req.ready             = req_ready;
    assign o_res.valid             = r_out_valid;
    assign o_res.triangle_num      = r_o_tri;
    assign o_res.edge_index        = r_o_edge;
    assign o_res.found             = r_o_found;
    assign o_res.neighbor_triangle = r_o_nb_tri;
    assign o_res.neighbor_edge     = r_o_nb_edge;
    assign o_res.status            = r_o_status;
    assign o_res.last_of_triangle  = r_o_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_hash_done_in_hash_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> ((r_state == metm_pkg::S_LK_HASH) || (r_state == metm_pkg::S_IN_HASH)))
        else $error("hash result arrived outside a hash wait state");

    a_home_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (32'(hash_slot) < 32'(TABLE_ENTRIES)))
        else $error("home slot beyond the table");

    a_full_counter_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_full) |-> (r_status == metm_pkg::ST_OVERFLOW))
        else $error("result of a rejected triangle without overflow status");

    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item |-> (r_edge <= metm_pkg::EDGE_LAST))
        else $error("edge counter ran past the third edge");
`endif

endmodule
`default_nettype wire

/* tb/mesh_edge_twin_matcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_edge_twin_matcher_tb: self-checking bench of the edge twin matcher
// Feeds triangles over the request channel, predicts every edge result with
// a behavioral copy of the hashed edge table, and checks each result in order.
// ----------------------------------------------------------------------------
module mesh_edge_twin_matcher_tb;

    localparam int unsigned TABLE_ENTRIES = metm_pkg::TABLE_ENTRIES_DEF;
    localparam int unsigned PROBE_LIMIT   = metm_pkg::PROBE_LIMIT_DEF;
    localparam int unsigned VERTEX_W      = metm_pkg::VERTEX_W;
    localparam int unsigned KEY_W         = metm_pkg::KEY_W;
    localparam int unsigned TRI_W         = metm_pkg::TRI_W;
    localparam int unsigned EDGE_W        = metm_pkg::EDGE_W;
    localparam int unsigned EDGES_PER_TRI = metm_pkg::EDGES_PER_TRI;

    // The stall limit covers a table sweep after a new mesh, a slow
    // triangle and random back-pressure several times over.
    localparam int unsigned STALL_LIMIT  = 8 * (TABLE_ENTRIES + 200);
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned MAX_REPORTS  = 40;
    localparam int unsigned RANDOM_ITEMS = 160;

    // One triangle request as queued for the driver. When hold_for_drain is
    // set, the driver keeps it back until every expected result has arrived.
    typedef struct {
        logic                new_mesh;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        bit                  hold_for_drain;
    } t_triangle_req;

    typedef struct {
        logic [TRI_W-1:0]  triangle_num;
        logic [EDGE_W-1:0] edge_index;
        logic              found;
        logic [TRI_W-1:0]  neighbor_triangle;
        logic [EDGE_W-1:0] neighbor_edge;
        metm_pkg::t_status status;
        logic              last_of_triangle;
    } t_edge_result;

    logic clk;
    logic rst_n;

    metm_req_if req_ch ();
    metm_res_if res_ch ();

    mesh_edge_twin_matcher #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PROBE_LIMIT   (PROBE_LIMIT)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Pending stimulus, the request currently on the bus, and the results
    // that the edge table model says are still owed by the block.
    t_triangle_req triangles_to_send [$];
    t_triangle_req request_on_bus;
    t_edge_result  edge_results_due [$];

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned quiet_cycles;

    // Both sides stop idling while this window of requests goes through, so
    // that the block also sees back-to-back traffic.
    wire calm_stretch = (requests_sent >= 70) && (requests_sent < 110);

    // ------------------------------------------------------------------------
    // Edge table model. Its own copy of the valid bits, keys, owners and edge
    // indexes, plus the triangle numbering and its overflow flag.
    // ------------------------------------------------------------------------
    bit                slot_used  [TABLE_ENTRIES];
    logic [KEY_W-1:0]  slot_key   [TABLE_ENTRIES];
    logic [TRI_W-1:0]  slot_owner [TABLE_ENTRIES];
    logic [EDGE_W-1:0] slot_edge  [TABLE_ENTRIES];
    logic [TRI_W-1:0]  next_triangle;
    bit                numbering_full;

    // Home slot: upper half of the 64-bit golden-ratio product, folded onto
    // the table size.
    function automatic int unsigned home_slot_of(input logic [KEY_W-1:0] key);
        logic [63:0] product;
        product = key * {metm_pkg::HASH_MUL_HI, metm_pkg::HASH_MUL_LO};
        return 32'((product >> 32) % TABLE_ENTRIES);
    endfunction

    function automatic void clear_edge_table();
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        next_triangle  = '0;
        numbering_full = 1'b0;
    endfunction

    // The probe stops at the first free slot, since entries are never removed.
    function automatic int find_twin_slot(input logic [KEY_W-1:0] key);
        int unsigned home;
        int unsigned slot;
        home = home_slot_of(key);
        for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
            slot = (home + i) % TABLE_ENTRIES;
            if (!slot_used[slot]) return -1;
            if (slot_key[slot] == key) return int'(slot);
        end
        return -1;
    endfunction

    // Stores the edge in the first free slot or the one with the same key.
    // Returns 0 when every probed slot holds some other edge.
    function automatic bit store_edge(input logic [KEY_W-1:0] key,
                                      input logic [TRI_W-1:0] owner,
                                      input logic [EDGE_W-1:0] edge_idx);
        int unsigned home;
        int unsigned slot;
        home = home_slot_of(key);
        for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
            slot = (home + i) % TABLE_ENTRIES;
            if (!slot_used[slot] || slot_key[slot] == key) begin
                slot_used[slot]  = 1'b1;
                slot_key[slot]   = key;
                slot_owner[slot] = owner;
                slot_edge[slot]  = edge_idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the result of each edge of one accepted triangle and queues
    // them in order, updating the table model on the way.
    function automatic void match_triangle_edges(input t_triangle_req t);
        logic [VERTEX_W-1:0] corner [EDGES_PER_TRI];
        logic [VERTEX_W-1:0] from_v;
        logic [VERTEX_W-1:0] to_v;
        logic [TRI_W-1:0]    this_tri;
        t_edge_result        r;
        int                  twin;
        if (t.new_mesh) clear_edge_table();
        corner[0] = t.vertex_a;
        corner[1] = t.vertex_b;
        corner[2] = t.vertex_c;
        this_tri  = next_triangle;
        for (int e = 0; e < EDGES_PER_TRI; e++) begin
            r.edge_index        = EDGE_W'(e);
            r.last_of_triangle  = (EDGE_W'(e) == metm_pkg::EDGE_LAST);
            r.found             = 1'b0;
            r.neighbor_triangle = '0;
            r.neighbor_edge     = '0;
            if (numbering_full) begin
                // Numbering has run out: the triangle is turned away.
                r.triangle_num = '0;
                r.status       = metm_pkg::ST_OVERFLOW;
            end else begin
                from_v         = corner[e];
                to_v           = corner[(e + 1) % EDGES_PER_TRI];
                r.triangle_num = this_tri;
                twin           = find_twin_slot({to_v, from_v});
                if (twin >= 0) begin
                    r.found             = 1'b1;
                    r.neighbor_triangle = slot_owner[twin];
                    r.neighbor_edge     = slot_edge[twin];
                    r.status            = metm_pkg::ST_OK;
                end else if (store_edge({from_v, to_v}, this_tri, EDGE_W'(e))) begin
                    r.status = metm_pkg::ST_OK;
                end else begin
                    r.status = metm_pkg::ST_FULL;
                end
            end
            edge_results_due.insert(edge_results_due.size(), r);
        end
        if (!numbering_full) begin
            if (this_tri == '1) begin
                next_triangle  = '0;
                numbering_full = 1'b1;
            end else begin
                next_triangle = this_tri + 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Reporting.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want, input logic [TRI_W-1:0] tri_num);
        if (got !== want)
            flag_mismatch($sformatf("triangle %0d %s got %0h want %0h",
                                    tri_num, what, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    task automatic queue_triangle(input logic nm, input logic [VERTEX_W-1:0] a,
                                  input logic [VERTEX_W-1:0] b,
                                  input logic [VERTEX_W-1:0] c, input bit hold);
        t_triangle_req t;
        t.new_mesh       = nm;
        t.vertex_a       = a;
        t.vertex_b       = b;
        t.vertex_c       = c;
        t.hold_for_drain = hold;
        triangles_to_send.insert(triangles_to_send.size(), t);
    endtask

    // Directed triangles: degenerate edges, extreme vertex values, twins,
    // overwriting an edge with the same key, a probe cluster that wraps the
    // end of the table until it is full, and clearing by a new mesh.
    task automatic queue_directed_triangles();
        logic [VERTEX_W-1:0] hub;
        logic [VERTEX_W-1:0] probe_v;
        logic [VERTEX_W-1:0] spoke [10];
        int unsigned         spokes;
        int unsigned         tries;
        // Every edge is the same self-loop: each later edge matches the first
        // one inside the same triangle.
        queue_triangle(1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
        queue_triangle(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_triangle(1'b0, 32'd1, 32'd2, 32'd3, 1'b0);
        queue_triangle(1'b0, 32'd2, 32'd1, 32'd4, 1'b0);
        queue_triangle(1'b0, 32'd3, 32'd2, 32'd5, 1'b0);
        // Edge 1-2 is stored again under the same key.
        queue_triangle(1'b0, 32'd1, 32'd2, 32'd3, 1'b0);
        queue_triangle(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        queue_triangle(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0);

        // Collect edges hub->spoke whose home slot sits three slots before the
        // end of the table, so the probe run wraps and then fills up.
        hub     = $urandom;
        probe_v = $urandom;
        spokes  = 0;
        tries   = 0;
        while (spokes < 10 && tries < (1 << 20)) begin
            if (home_slot_of({hub, probe_v}) == TABLE_ENTRIES - 3) begin
                spoke[spokes] = probe_v;
                spokes++;
            end
            probe_v++;
            tries++;
        end
        for (int unsigned i = 0; i < spokes; i++)
            queue_triangle(i == 0, hub, spoke[i], spoke[i], 1'b0);
        if (spokes == 10) begin
            // The first twin in the cluster, then one that was dropped, which
            // walks the whole probe run without a hit.
            queue_triangle(1'b0, spoke[0], hub, 32'd7, 1'b0);
            queue_triangle(1'b0, spoke[9], hub, 32'd9, 1'b0);
            queue_triangle(1'b1, spoke[0], hub, 32'd7, 1'b0);
        end
    endtask

    // Random meshes. Most segments are well formed: strips that reuse an
    // edge of the previous triangle in reverse, or triangles over a small
    // vertex pool. The rest is noise over the full vertex range.
    task automatic queue_random_meshes(input int unsigned item_count);
        logic [VERTEX_W-1:0] base;
        logic [VERTEX_W-1:0] corner [EDGES_PER_TRI];
        logic [VERTEX_W-1:0] u;
        logic [VERTEX_W-1:0] v;
        logic [VERTEX_W-1:0] w;
        logic [VERTEX_W-1:0] n0;
        int unsigned         made;
        int unsigned         seg_left;
        int unsigned         shape;
        int unsigned         fresh;
        int unsigned         pick;
        bit                  hold;
        made     = 0;
        seg_left = 0;
        shape    = 0;
        fresh    = 0;
        base     = '0;
        while (made < item_count) begin
            hold = (made == 0) || ($urandom_range(0, 39) == 0);
            if (seg_left == 0) begin
                seg_left  = $urandom_range(6, 30);
                shape     = $urandom_range(0, 9);
                base      = $urandom;
                fresh     = 3;
                corner[0] = base;
                corner[1] = base + 1;
                corner[2] = base + 2;
                queue_triangle($urandom_range(0, 3) != 0, corner[0], corner[1],
                               corner[2], hold);
            end else if (shape >= 8 || $urandom_range(0, 9) == 0) begin
                n0 = $urandom;
                queue_triangle($urandom_range(0, 31) == 0, n0,
                               ($urandom_range(0, 7) == 0) ? n0 : $urandom,
                               $urandom, hold);
            end else if (shape >= 5) begin
                queue_triangle(1'b0, base + $urandom_range(0, 5),
                               base + $urandom_range(0, 5),
                               base + $urandom_range(0, 5), hold);
            end else begin
                // Grow the strip across a reversed edge of the last triangle.
                pick = $urandom_range(0, 2);
                u    = corner[pick];
                v    = corner[(pick + 1) % EDGES_PER_TRI];
                if ($urandom_range(0, 3) == 0) begin
                    w = base + $urandom_range(0, fresh - 1);
                end else begin
                    w = base + fresh;
                    fresh++;
                end
                case ($urandom_range(0, 2))
                    0: begin
                        corner[0] = v; corner[1] = u; corner[2] = w;
                    end
                    1: begin
                        corner[0] = u; corner[1] = w; corner[2] = v;
                    end
                    default: begin
                        corner[0] = w; corner[1] = v; corner[2] = u;
                    end
                endcase
                queue_triangle(1'b0, corner[0], corner[1], corner[2], hold);
            end
            seg_left--;
            made++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver. A request stays on the bus until it is accepted. A new
    // one is only put up when the bus is free after this edge, and valid gets
    // at most one assignment per edge. The prediction of a request is made at
    // the edge that accepts it; its results only come later, from the output
    // register, so the monitor never looks for them in the same step.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                match_triangle_edges(request_on_bus);
                requests_sent <= requests_sent + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (triangles_to_send.size() != 0
                        && (calm_stretch || $urandom_range(0, 99) >= 32)
                        && !(triangles_to_send[0].hold_for_drain
                             && edge_results_due.size() != 0)) begin
                    request_on_bus    = triangles_to_send.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.new_mesh  <= request_on_bus.new_mesh;
                    req_ch.vertex_a  <= request_on_bus.vertex_a;
                    req_ch.vertex_b  <= request_on_bus.vertex_b;
                    req_ch.vertex_c  <= request_on_bus.vertex_c;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each accepted result is held against the oldest
    // expectation, field by field. Ready drops at random outside the calm
    // stretch.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_edge_result want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (edge_results_due.size() == 0) begin
                    flag_mismatch($sformatf("result for triangle %0d edge %0d not expected",
                                            res_ch.triangle_num, res_ch.edge_index));
                end else begin
                    want = edge_results_due.pop_front();
                    check_field("triangle_num", 32'(res_ch.triangle_num),
                                32'(want.triangle_num), want.triangle_num);
                    check_field("edge_index", 32'(res_ch.edge_index),
                                32'(want.edge_index), want.triangle_num);
                    check_field("found", 32'(res_ch.found), 32'(want.found),
                                want.triangle_num);
                    check_field("neighbor_triangle", 32'(res_ch.neighbor_triangle),
                                32'(want.neighbor_triangle), want.triangle_num);
                    check_field("neighbor_edge", 32'(res_ch.neighbor_edge),
                                32'(want.neighbor_edge), want.triangle_num);
                    check_field("status", 32'(res_ch.status), 32'(want.status),
                                want.triangle_num);
                    check_field("last_of_triangle", 32'(res_ch.last_of_triangle),
                                32'(want.last_of_triangle), want.triangle_num);
                end
            end
            res_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= 32);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any accepted request or result is a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("mesh_edge_twin_matcher_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the stimulus, hold reset, let the driver run dry, wait
    // for the last result plus a tail for stray ones, then give the verdict.
    // ------------------------------------------------------------------------
    initial begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.new_mesh = 1'b0;
        req_ch.vertex_a = '0;
        req_ch.vertex_b = '0;
        req_ch.vertex_c = '0;
        res_ch.ready    = 1'b0;
        mismatches      = 0;
        requests_sent   = 0;
        quiet_cycles    = 0;
        clear_edge_table();

        queue_directed_triangles();
        queue_random_meshes(RANDOM_ITEMS);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (triangles_to_send.size() != 0 || req_ch.valid) @(posedge clk);
        while (edge_results_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("mesh_edge_twin_matcher_tb OK");
        end else begin
            $display("mesh_edge_twin_matcher_tb NOT OK");
        end
        $finish;
    end

endmodule

/* mesh_edge_twin_matcher.f */
rtl/metm_pkg.sv
rtl/metm_req_if.sv
rtl/metm_res_if.sv
rtl/metm_hash.sv
rtl/mesh_edge_twin_matcher.sv
tb/mesh_edge_twin_matcher_tb.sv
